// ===== rtl/core/plmf_pkg.sv =====
package plmf_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   typedef enum logic [2:0] {
      CSR_PHY_ADDRESS       = 3'd0,
      CSR_SPEED_REG_ADDRESS = 3'd1,
      CSR_SPEED_DUPLEX_MASK = 3'd2,
      CSR_CODE_10_FULL      = 3'd3,
      CSR_CODE_100_FULL     = 3'd4,
      CSR_CODE_100_HALF     = 3'd5,
      CSR_CODE_10_HALF      = 3'd6,
      CSR_UNUSED            = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      EVT_START   = 2'd0,
      EVT_STOP    = 2'd1,
      EVT_ADVANCE = 2'd2,
      EVT_NONE    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_RSVD  = 2'd3
   } mdio_op_type;

   localparam logic [4:0]  RegBmcr       = 5'd0;
   localparam logic [4:0]  RegBmsr       = 5'd1;
   localparam logic [4:0]  RegAnar       = 5'd4;
   localparam logic [15:0] BmcrReset     = 16'h8000;
   localparam logic [15:0] BmcrAnRestart = 16'h1200;
   localparam logic [15:0] AnarAll       = 16'h01E1;
   localparam int unsigned BmsrLinkBit   = 2;

   localparam logic [4:0]  RstPhyAddress     = 5'd0;
   localparam logic [4:0]  RstSpeedRegAddress = 5'd30;
   localparam logic [15:0] RstSpeedDuplexMask = 16'd7;
   localparam logic [15:0] RstCode10Full     = 16'd5;
   localparam logic [15:0] RstCode100Full    = 16'd6;
   localparam logic [15:0] RstCode100Half    = 16'd2;
   localparam logic [15:0] RstCode10Half     = 16'd1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] read_data;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  mdio_op;
      logic [4:0]  mdio_phy;
      logic [4:0]  mdio_reg;
      logic [15:0] mdio_wdata;
      logic        rx_activate;
      logic        arm_poll;
      logic        cancel_poll;
      logic        mac_update;
      logic        link_is_up;
      logic        speed_is_100;
      logic        duplex_is_full;
      logic [2:0]  fsm_state;
   } rsp_item_type;

endpackage

// ===== rtl/core/phy_link_management_fsm.sv =====
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid/req_stall  | req_item (mode, read_data)
// rsp      | out       | rsp_valid/rsp_stall  | rsp_item (access, pulses, status)
// csr      | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
// One item per cycle unless stalled: the next state and result are computed
// combinationally from the accepted item and the state registers; the result
// is registered in the output register, or in the skid register if it is held.
// A skid register behind the output register absorbs one more item, so
// req_stall rises only when both are full.
// Synchronous reset clears the state, the flags, the valid bits and the
// configuration registers to their default values.
module phy_link_management_fsm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  plmf_pkg::req_item_type               req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output plmf_pkg::rsp_item_type               rsp_item,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [plmf_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [plmf_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [plmf_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready
);

   typedef enum logic [2:0] {
      ST_INITIAL = 3'd0,
      ST_RESET   = 3'd1,
      ST_AUTONEG = 3'd2,
      ST_RESTART = 3'd3,
      ST_STATUS  = 3'd4,
      ST_DUPLEX  = 3'd5,
      ST_WAIT    = 3'd6,
      ST_CLOSING = 3'd7
   } state_type;

   state_type state_ff, state_in;
   logic enabled_ff, enabled_in;
   logic link_ff, link_in;
   logic speed_ff, speed_in;
   logic duplex_ff, duplex_in;

   logic [4:0]  phy_address_ff;
   logic [4:0]  speed_reg_address_ff;
   logic [15:0] speed_duplex_mask_ff;
   logic [15:0] code_10_full_ff;
   logic [15:0] code_100_full_ff;
   logic [15:0] code_100_half_ff;
   logic [15:0] code_10_half_ff;

   plmf_pkg::rsp_item_type out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   plmf_pkg::rsp_item_type result;
   plmf_pkg::csr_index_type csr_index;
   logic accept, take, csr_write;
   logic [15:0] code;
   logic sp, fd, up;

   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;
   assign pready    = 1'b1;
   assign csr_index = plmf_pkg::csr_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (csr_index)
         plmf_pkg::CSR_PHY_ADDRESS:       prdata = {27'd0, phy_address_ff};
         plmf_pkg::CSR_SPEED_REG_ADDRESS: prdata = {27'd0, speed_reg_address_ff};
         plmf_pkg::CSR_SPEED_DUPLEX_MASK: prdata = {16'd0, speed_duplex_mask_ff};
         plmf_pkg::CSR_CODE_10_FULL:      prdata = {16'd0, code_10_full_ff};
         plmf_pkg::CSR_CODE_100_FULL:     prdata = {16'd0, code_100_full_ff};
         plmf_pkg::CSR_CODE_100_HALF:     prdata = {16'd0, code_100_half_ff};
         plmf_pkg::CSR_CODE_10_HALF:      prdata = {16'd0, code_10_half_ff};
         default:                         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phy_address_ff       <= plmf_pkg::RstPhyAddress;
         speed_reg_address_ff <= plmf_pkg::RstSpeedRegAddress;
         speed_duplex_mask_ff <= plmf_pkg::RstSpeedDuplexMask;
         code_10_full_ff      <= plmf_pkg::RstCode10Full;
         code_100_full_ff     <= plmf_pkg::RstCode100Full;
         code_100_half_ff     <= plmf_pkg::RstCode100Half;
         code_10_half_ff      <= plmf_pkg::RstCode10Half;
      end else if (csr_write) begin
         unique case (csr_index)
            plmf_pkg::CSR_PHY_ADDRESS:       phy_address_ff       <= pwdata[4:0];
            plmf_pkg::CSR_SPEED_REG_ADDRESS: speed_reg_address_ff <= pwdata[4:0];
            plmf_pkg::CSR_SPEED_DUPLEX_MASK: speed_duplex_mask_ff <= pwdata[15:0];
            plmf_pkg::CSR_CODE_10_FULL:      code_10_full_ff      <= pwdata[15:0];
            plmf_pkg::CSR_CODE_100_FULL:     code_100_full_ff     <= pwdata[15:0];
            plmf_pkg::CSR_CODE_100_HALF:     code_100_half_ff     <= pwdata[15:0];
            plmf_pkg::CSR_CODE_10_HALF:      code_10_half_ff      <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // decode vendor speed/duplex code, first match wins
   always_comb begin
      code = req_item.read_data & speed_duplex_mask_ff;
      priority if (code == code_10_full_ff) begin
         sp = 1'b0; fd = 1'b1;
      end else if (code == code_100_full_ff) begin
         sp = 1'b1; fd = 1'b1;
      end else if (code == code_100_half_ff) begin
         sp = 1'b1; fd = 1'b0;
      end else if (code == code_10_half_ff) begin
         sp = 1'b0; fd = 1'b0;
      end else begin
         sp = 1'b1; fd = 1'b1;
      end
   end

   assign up = req_item.read_data[plmf_pkg::BmsrLinkBit];

   always_comb begin
      state_in   = state_ff;
      enabled_in = enabled_ff;
      link_in    = link_ff;
      speed_in   = speed_ff;
      duplex_in  = duplex_ff;
      result     = '0;
      unique case (plmf_pkg::event_type'(req_item.mode))
         plmf_pkg::EVT_START: begin
            enabled_in = 1'b1;
            if (state_ff == ST_INITIAL) begin
               result.rx_activate = 1'b1;
               result.mdio_op     = plmf_pkg::OP_WRITE;
               result.mdio_reg    = plmf_pkg::RegBmcr;
               result.mdio_wdata  = plmf_pkg::BmcrReset;
               state_in           = ST_RESET;
            end
         end
         plmf_pkg::EVT_STOP: begin
            enabled_in = 1'b0;
            if (state_ff == ST_WAIT) begin
               result.cancel_poll = 1'b1;
               state_in           = ST_INITIAL;
            end else if (state_ff != ST_CLOSING) begin
               state_in = ST_CLOSING;
            end
         end
         plmf_pkg::EVT_ADVANCE: begin
            unique case (state_ff)
               ST_CLOSING: begin
                  if (enabled_ff) begin
                     result.mdio_op    = plmf_pkg::OP_WRITE;
                     result.mdio_reg   = plmf_pkg::RegBmcr;
                     result.mdio_wdata = plmf_pkg::BmcrReset;
                     state_in          = ST_RESET;
                  end else begin
                     state_in = ST_INITIAL;
                  end
               end
               ST_RESET: begin
                  result.mdio_op    = plmf_pkg::OP_WRITE;
                  result.mdio_reg   = plmf_pkg::RegAnar;
                  result.mdio_wdata = plmf_pkg::AnarAll;
                  state_in          = ST_AUTONEG;
               end
               ST_AUTONEG: begin
                  result.mdio_op    = plmf_pkg::OP_WRITE;
                  result.mdio_reg   = plmf_pkg::RegBmcr;
                  result.mdio_wdata = plmf_pkg::BmcrAnRestart;
                  state_in          = ST_RESTART;
               end
               ST_WAIT, ST_RESTART: begin
                  result.mdio_op  = plmf_pkg::OP_READ;
                  result.mdio_reg = plmf_pkg::RegBmsr;
                  state_in        = ST_STATUS;
               end
               ST_STATUS: begin
                  if (up && !link_ff) begin
                     result.mdio_op  = plmf_pkg::OP_READ;
                     result.mdio_reg = speed_reg_address_ff;
                     link_in         = 1'b1;
                     state_in        = ST_DUPLEX;
                  end else begin
                     link_in         = up;
                     result.arm_poll = 1'b1;
                     state_in        = ST_WAIT;
                  end
               end
               ST_DUPLEX: begin
                  if (sp != speed_ff || fd != duplex_ff) begin
                     speed_in          = sp;
                     duplex_in         = fd;
                     result.mac_update = 1'b1;
                  end
                  result.arm_poll = 1'b1;
                  state_in        = ST_WAIT;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (result.mdio_op != plmf_pkg::OP_NONE) begin
         result.mdio_phy = phy_address_ff;
      end
      result.link_is_up     = link_in;
      result.speed_is_100   = speed_in;
      result.duplex_is_full = duplex_in;
      result.fsm_state      = state_in;
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         state_ff      <= ST_INITIAL;
         enabled_ff    <= 1'b0;
         link_ff       <= 1'b0;
         speed_ff      <= 1'b1;
         duplex_ff     <= 1'b1;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            state_ff   <= state_in;
            enabled_ff <= enabled_in;
            link_ff    <= link_in;
            speed_ff   <= speed_in;
            duplex_ff  <= duplex_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while output register is empty");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> out_valid_ff)
      else $error("accepted item did not reach the output register");

   a_idle_access_clear: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.mdio_op == plmf_pkg::OP_NONE) |->
      (out_ff.mdio_phy == 5'd0 && out_ff.mdio_reg == 5'd0 && out_ff.mdio_wdata == 16'd0))
      else $error("access fields set without an access");

   a_poll_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.arm_poll && out_ff.cancel_poll))
      else $error("poll timer armed and canceled together");

   a_state_matches: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == state_type'($past(result.fsm_state))))
      else $error("stored state differs from reported state");
`endif

endmodule
